>>> src/dmpc_pkg.sv
package dmpc_pkg;

   localparam int H_W        = 12;
   localparam int MAR_W      = 8;
   localparam int SPD_W      = 8;
   localparam int TIME_W     = 32;
   localparam int OP_W       = 3;
   localparam int MOT_W      = 2;
   localparam int STS_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // travel so far kept as quotient and remainder of speed * elapsed / 1000
   localparam int Q_W        = 12;
   localparam int R_W        = 10;
   localparam int MS_PER_S   = 1000;
   localparam int PROD_W     = SPD_W + TIME_W;

   // reciprocal for products below 2^22: floor(x / 1000) = (x * RECIP) >> 32
   localparam int SMALL_W     = 22;
   localparam int RECIP_W     = 23;
   localparam int RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'(4294968);
   localparam logic [PROD_W-1:0]  Q_SAT_LIMIT = PROD_W'(4095000);

   localparam logic [H_W-1:0]  H_MAX  = {H_W{1'b1}};
   localparam logic [Q_W-1:0]  Q_MAX  = {Q_W{1'b1}};
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic [H_W-1:0]   MIN_HEIGHT_RST = H_W'(600);
   localparam logic [H_W-1:0]   MAX_HEIGHT_RST = H_W'(1300);
   localparam logic [MAR_W-1:0] MARGIN_RST     = MAR_W'(10);
   localparam logic [SPD_W-1:0] UP_SPEED_RST   = SPD_W'(30);
   localparam logic [SPD_W-1:0] DOWN_SPEED_RST = SPD_W'(30);

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_UP     = 3'd1,
      OP_DOWN   = 3'd2,
      OP_STOP   = 3'd3,
      OP_TARGET = 3'd4,
      OP_LOAD   = 3'd5
   } opcode_type;

   typedef enum logic [MOT_W-1:0] {
      MOT_STOP = 2'd0,
      MOT_UP   = 2'd1,
      MOT_DOWN = 2'd2
   } motion_type;

   typedef enum logic [STS_W-1:0] {
      STS_ACCEPTED     = 2'd0,
      STS_AT_TARGET    = 2'd1,
      STS_OUT_OF_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_HEIGHT = 3'd0,
      CSR_MAX_HEIGHT = 3'd1,
      CSR_MARGIN     = 3'd2,
      CSR_UP_SPEED   = 3'd3,
      CSR_DOWN_SPEED = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [H_W-1:0]   min_height;
      logic [H_W-1:0]   max_height;
      logic [MAR_W-1:0] margin;
      logic [SPD_W-1:0] up_speed;
      logic [SPD_W-1:0] down_speed;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [TIME_W-1:0] duration_ms;
      logic [H_W-1:0]    target_mm;
      logic [H_W-1:0]    load_height_mm;
   } req_item_type;

   typedef struct packed {
      logic             motor_up;
      logic             motor_down;
      logic [H_W-1:0]   height_mm;
      logic [MOT_W-1:0] motion;
      logic             position_saved;
      logic [STS_W-1:0] command_status;
   } rsp_item_type;

   typedef struct packed {
      logic [Q_W-1:0] q;
      logic [R_W-1:0] r;
   } qr_type;

   typedef struct packed {
      logic   load;
      qr_type up;
      qr_type down;
   } rescale_type;

   // one more millisecond of travel at speed spd
   function automatic qr_type qr_step(input qr_type qr, input logic [SPD_W-1:0] spd);
      logic [R_W:0] rs;
      qr_type       res;
      rs  = {1'b0, qr.r} + (R_W+1)'(spd);
      res = qr;
      if (rs >= (R_W+1)'(MS_PER_S)) begin
         res.r = R_W'(rs - (R_W+1)'(MS_PER_S));
         if (qr.q != Q_MAX) begin
            res.q = qr.q + 1'b1;
         end
      end else begin
         res.r = rs[R_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> src/dmpc_if.sv
interface dmpc_req_if;
   import dmpc_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [TIME_W-1:0] duration_ms;
   logic [H_W-1:0]    target_mm;
   logic [H_W-1:0]    load_height_mm;

   modport source (output valid, output opcode, output duration_ms, output target_mm,
                   output load_height_mm, input ready);
   modport sink   (input valid, input opcode, input duration_ms, input target_mm,
                   input load_height_mm, output ready);
endinterface

interface dmpc_rsp_if;
   import dmpc_pkg::*;

   logic             valid;
   logic             ready;
   logic             motor_up;
   logic             motor_down;
   logic [H_W-1:0]   height_mm;
   logic [MOT_W-1:0] motion;
   logic             position_saved;
   logic [STS_W-1:0] command_status;

   modport source (output valid, output motor_up, output motor_down, output height_mm,
                   output motion, output position_saved, output command_status,
                   input ready);
   modport sink   (input valid, input motor_up, input motor_down, input height_mm,
                   input motion, input position_saved, input command_status,
                   output ready);
endinterface

>>> src/dmpc_csr.sv
module dmpc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [dmpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dmpc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output dmpc_pkg::cfg_type                  cfg,
   output logic                               speed_wr
);
   import dmpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in   = cfg_ff;
      speed_wr = 1'b0;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_HEIGHT: cfg_in.min_height = csr_wdata[H_W-1:0];
            CSR_MAX_HEIGHT: cfg_in.max_height = csr_wdata[H_W-1:0];
            CSR_MARGIN:     cfg_in.margin     = csr_wdata[MAR_W-1:0];
            CSR_UP_SPEED: begin
               cfg_in.up_speed = csr_wdata[SPD_W-1:0];
               speed_wr        = 1'b1;
            end
            CSR_DOWN_SPEED: begin
               cfg_in.down_speed = csr_wdata[SPD_W-1:0];
               speed_wr          = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_height <= MIN_HEIGHT_RST;
         cfg_ff.max_height <= MAX_HEIGHT_RST;
         cfg_ff.margin     <= MARGIN_RST;
         cfg_ff.up_speed   <= UP_SPEED_RST;
         cfg_ff.down_speed <= DOWN_SPEED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/dmpc_rescale.sv
module dmpc_rescale (
   input  logic                           clock,
   input  logic                           reset,
   input  dmpc_pkg::cfg_type              cfg,
   input  logic [dmpc_pkg::TIME_W-1:0]    elapsed,
   input  logic                           speed_wr,
   output dmpc_pkg::rescale_type          rescale,
   output logic                           busy
);
   import dmpc_pkg::*;

   localparam int LANES = 2;
   localparam int MUL_W = SMALL_W + RECIP_W;

   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;
   logic [PROD_W-1:0] prod_ff [LANES];
   logic [PROD_W-1:0] prod_in [LANES];
   logic [Q_W-1:0]    quo_ff  [LANES];
   logic [Q_W-1:0]    quo_in  [LANES];
   logic [MUL_W-1:0]  recip_prod [LANES];
   logic [SMALL_W-1:0] rem_full  [LANES];
   logic [SPD_W-1:0]  lane_speed [LANES];
   qr_type            lane_qr    [LANES];

   assign lane_speed[0] = cfg.up_speed;
   assign lane_speed[1] = cfg.down_speed;

   // speed * elapsed, then quotient by reciprocal, then remainder
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         prod_in[i]    = PROD_W'(lane_speed[i]) * PROD_W'(elapsed);
         recip_prod[i] = MUL_W'(prod_ff[i][SMALL_W-1:0]) * MUL_W'(RECIP);
         if (prod_ff[i] >= Q_SAT_LIMIT) begin
            quo_in[i] = Q_MAX;
         end else begin
            quo_in[i] = recip_prod[i][RECIP_SHIFT +: Q_W];
         end
         rem_full[i]   = prod_ff[i][SMALL_W-1:0]
                         - SMALL_W'(quo_ff[i]) * SMALL_W'(MS_PER_S);
         lane_qr[i].q  = quo_ff[i];
         lane_qr[i].r  = (quo_ff[i] == Q_MAX) ? '0 : rem_full[i][R_W-1:0];
      end
   end

   always_comb begin
      if (speed_wr) begin
         cnt_in = 2'd3;
      end else if (cnt_ff != 2'd0) begin
         cnt_in = cnt_ff - 2'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         prod_ff[i] <= prod_in[i];
         quo_ff[i]  <= quo_in[i];
      end
   end

   assign busy         = (cnt_ff != 2'd0);
   assign rescale.load = (cnt_ff == 2'd1);
   assign rescale.up   = lane_qr[0];
   assign rescale.down = lane_qr[1];

endmodule

>>> src/dmpc_core.sv
module dmpc_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  dmpc_pkg::req_item_type         item,
   input  dmpc_pkg::cfg_type              cfg,
   input  dmpc_pkg::rescale_type          rescale,
   output logic [dmpc_pkg::TIME_W-1:0]    elapsed,
   output dmpc_pkg::rsp_item_type         result
);
   import dmpc_pkg::*;

   logic [H_W-1:0]    current_ff, current_in;
   logic [H_W-1:0]    base_ff,    base_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   motion_type        actual_ff,  actual_in;
   motion_type        wanted_ff,  wanted_in;
   logic [TIME_W-1:0] limit_ff,   limit_in;
   logic [H_W-1:0]    target_ff,  target_in;
   qr_type            up_ff,      up_in;
   qr_type            down_ff,    down_in;

   // thresholds, widened so that nothing wraps
   logic signed [H_W+1:0] top_s;
   logic        [H_W:0]   bottom;
   logic signed [H_W+1:0] win_lo;
   logic        [H_W:0]   win_hi;

   // tick path
   logic              inc;
   logic [TIME_W-1:0] el1, el2;
   qr_type            up1, down1, up2, down2;
   logic [H_W:0]      up_sum;
   logic [H_W-1:0]    h;
   motion_type        act2;
   logic [H_W-1:0]    base2;
   logic              saved2;
   logic              above, below, in_win, timeout, stop_req;

   // move to target path
   logic signed [H_W:0] diff;
   logic        [H_W:0] abs_diff;
   logic                at_target, in_range;

   logic       saved;
   status_type status;

   assign top_s  = $signed({2'b00, cfg.max_height}) - $signed({6'b0, cfg.margin});
   assign bottom = {1'b0, cfg.min_height} + (H_W+1)'(cfg.margin);
   assign win_lo = $signed({2'b00, target_ff}) - $signed({6'b0, cfg.margin});
   assign win_hi = {1'b0, target_ff} + (H_W+1)'(cfg.margin);

   always_comb begin
      inc   = (actual_ff != MOT_STOP) && (elapsed_ff != TIME_MAX);
      el1   = elapsed_ff + TIME_W'(inc);
      up1   = inc ? qr_step(up_ff, cfg.up_speed) : up_ff;
      down1 = inc ? qr_step(down_ff, cfg.down_speed) : down_ff;

      up_sum = {1'b0, base_ff} + {1'b0, up1.q};
      unique case (actual_ff)
         MOT_UP:   h = up_sum[H_W] ? H_MAX : up_sum[H_W-1:0];
         MOT_DOWN: begin
            if (base_ff > down1.q) begin
               h = base_ff - down1.q - H_W'(down1.r != '0);
            end else begin
               h = '0;
            end
         end
         default:  h = current_ff;
      endcase

      above = $signed({2'b00, h}) > top_s;
      below = {1'b0, h} < bottom;

      act2   = actual_ff;
      base2  = base_ff;
      el2    = el1;
      up2    = up1;
      down2  = down1;
      saved2 = 1'b0;
      if (actual_ff != wanted_ff) begin
         unique case (wanted_ff)
            MOT_UP: begin
               if (!above) act2 = MOT_UP;
            end
            MOT_DOWN: begin
               if (!below) act2 = MOT_DOWN;
            end
            default: begin
               // stop takes effect: rebase and restart the travel count
               act2   = MOT_STOP;
               base2  = h;
               el2    = '0;
               up2    = '0;
               down2  = '0;
               saved2 = 1'b1;
            end
         endcase
      end

      in_win   = ($signed({2'b00, h}) > win_lo) && ({1'b0, h} < win_hi);
      timeout  = (act2 != MOT_STOP) && (limit_ff != '0) && (el2 >= limit_ff);
      stop_req = timeout || ((act2 == MOT_UP) && above)
                 || ((act2 == MOT_DOWN) && below) || in_win;
   end

   always_comb begin
      diff      = $signed({1'b0, current_ff}) - $signed({1'b0, item.target_mm});
      abs_diff  = diff[H_W] ? (H_W+1)'(-diff) : diff;
      at_target = abs_diff <= (H_W+1)'(cfg.margin);
      in_range  = ({1'b0, item.target_mm} > bottom)
                  && ($signed({2'b00, item.target_mm}) < top_s);
   end

   always_comb begin
      current_in = current_ff;
      base_in    = base_ff;
      elapsed_in = elapsed_ff;
      actual_in  = actual_ff;
      wanted_in  = wanted_ff;
      limit_in   = limit_ff;
      target_in  = target_ff;
      up_in      = up_ff;
      down_in    = down_ff;
      saved      = 1'b0;
      status     = STS_ACCEPTED;
      if (step) begin
         unique case (opcode_type'(item.opcode))
            OP_TICK: begin
               current_in = h;
               base_in    = base2;
               elapsed_in = el2;
               actual_in  = act2;
               up_in      = up2;
               down_in    = down2;
               saved      = saved2;
               if (stop_req) begin
                  wanted_in = MOT_STOP;
                  limit_in  = '0;
               end
            end
            OP_UP: begin
               wanted_in = MOT_UP;
               limit_in  = item.duration_ms;
            end
            OP_DOWN: begin
               wanted_in = MOT_DOWN;
               limit_in  = item.duration_ms;
            end
            OP_STOP: begin
               wanted_in = MOT_STOP;
               limit_in  = '0;
            end
            OP_TARGET: begin
               if (at_target) begin
                  status = STS_AT_TARGET;
               end else if (!in_range) begin
                  status = STS_OUT_OF_RANGE;
               end else begin
                  target_in = item.target_mm;
                  wanted_in = (current_ff < item.target_mm) ? MOT_UP : MOT_DOWN;
               end
            end
            OP_LOAD: begin
               current_in = item.load_height_mm;
               base_in    = item.load_height_mm;
            end
            default: ;
         endcase
      end
      if (rescale.load) begin
         up_in   = rescale.up;
         down_in = rescale.down;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= '0;
         base_ff    <= '0;
         elapsed_ff <= '0;
         actual_ff  <= MOT_STOP;
         wanted_ff  <= MOT_STOP;
         limit_ff   <= '0;
         target_ff  <= '0;
         up_ff      <= '0;
         down_ff    <= '0;
      end else begin
         current_ff <= current_in;
         base_ff    <= base_in;
         elapsed_ff <= elapsed_in;
         actual_ff  <= actual_in;
         wanted_ff  <= wanted_in;
         limit_ff   <= limit_in;
         target_ff  <= target_in;
         up_ff      <= up_in;
         down_ff    <= down_in;
      end
   end

   assign elapsed = elapsed_ff;

   assign result.motor_up       = (actual_in == MOT_UP);
   assign result.motor_down     = (actual_in == MOT_DOWN);
   assign result.height_mm      = current_in;
   assign result.motion         = actual_in;
   assign result.position_saved = saved;
   assign result.command_status = status;

endmodule

>>> src/desk_motor_position_controller.sv
// Desk motor controller with dead-reckoned height estimate.
// req_ch carries one command per transfer: tick (one millisecond passes), move up,
// move down, stop, move to target or load position. Every request yields exactly
// one rsp_ch transfer with the motor pin levels, estimated height, motion, the
// position_saved pulse and the command status, in request order.
// The csr_ port writes the five registers (min, max, margin, up and down speed)
// with no read-back; write them only while no request is in flight.
// A request is captured in the input register, evaluated in a single pass once
// the output register is free, and captured in the output register that drives
// rsp_ch. One request is taken per cycle while rsp_ch is ready and no rescale runs.
// Travel is kept as quotient and remainder of speed * elapsed / 1000, so a tick
// needs only an add and a compare. A write to either speed register rescales
// those counts through a pipelined multiply; req_ch.ready is low during the write
// and while the rescale is busy.
// Reset (synchronous, active high) restores the default registers, stops both
// motors and clears height, timer and target.
// A stalled rsp_ch holds its result; the input register still takes one more
// request, then req_ch.ready drops until the output moves.
module desk_motor_position_controller (
   input  logic                              clock,
   input  logic                              reset,
   dmpc_req_if.sink                          req_ch,
   dmpc_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [dmpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dmpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dmpc_pkg::*;

   cfg_type      cfg;
   logic         speed_wr;
   rescale_type  rescale;
   logic         busy;
   logic [TIME_W-1:0] elapsed;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff,  in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff,  out_item_in;
   logic         advance;
   logic         req_xfer;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = (!in_valid_ff || advance) && !busy && !speed_wr;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign in_item_in.opcode         = req_ch.opcode;
   assign in_item_in.duration_ms    = req_ch.duration_ms;
   assign in_item_in.target_mm      = req_ch.target_mm;
   assign in_item_in.load_height_mm = req_ch.load_height_mm;

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   dmpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .speed_wr  (speed_wr)
   );

   dmpc_rescale u_rescale (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .elapsed  (elapsed),
      .speed_wr (speed_wr),
      .rescale  (rescale),
      .busy     (busy)
   );

   dmpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .rescale (rescale),
      .elapsed (elapsed),
      .result  (out_item_in)
   );

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.motor_up       = out_item_ff.motor_up;
   assign rsp_ch.motor_down     = out_item_ff.motor_down;
   assign rsp_ch.height_mm      = out_item_ff.height_mm;
   assign rsp_ch.motion         = out_item_ff.motion;
   assign rsp_ch.position_saved = out_item_ff.position_saved;
   assign rsp_ch.command_status = out_item_ff.command_status;

endmodule

>>> src/dmpc_checker.sv
module dmpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           motor_up,
   input logic                           motor_down,
   input logic [dmpc_pkg::H_W-1:0]       height_mm,
   input logic [dmpc_pkg::MOT_W-1:0]     motion,
   input logic                           position_saved,
   input logic [dmpc_pkg::STS_W-1:0]     command_status
);
   import dmpc_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable({motor_up, motor_down, height_mm, motion, position_saved,
                     command_status}))
      else $error("stalled response changed");

   a_pins_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (motor_up == (motion == MOT_UP))
                    && (motor_down == (motion == MOT_DOWN)))
      else $error("motor pins disagree with motion");

   a_saved_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && position_saved |-> (motion == MOT_STOP)
                                      && (command_status == STS_ACCEPTED))
      else $error("position saved while moving or on a command");

endmodule

bind desk_motor_position_controller dmpc_checker u_dmpc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .motor_up       (rsp_ch.motor_up),
   .motor_down     (rsp_ch.motor_down),
   .height_mm      (rsp_ch.height_mm),
   .motion         (rsp_ch.motion),
   .position_saved (rsp_ch.position_saved),
   .command_status (rsp_ch.command_status)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import dmpc_pkg::*;

   // opcodes beyond the defined set, the block must leave its state alone
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   localparam int GAP_PCT        = 13;
   localparam int HOLD_CYCLES    = 60;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_PRINTS     = 50;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dmpc_req_if req_bus ();
   dmpc_rsp_if rsp_bus ();

   desk_motor_position_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies
   logic [H_W-1:0]    lim_min;
   logic [H_W-1:0]    lim_max;
   logic [MAR_W-1:0]  tol_mm;
   logic [SPD_W-1:0]  up_rate;
   logic [SPD_W-1:0]  down_rate;

   // dead-reckoning state
   logic [H_W-1:0]    est_height;
   logic [H_W-1:0]    base_mm;
   logic [TIME_W-1:0] run_ms;
   motion_type        actual_mv;
   motion_type        wanted_mv;
   logic [TIME_W-1:0] limit_ms;
   logic [H_W-1:0]    goal_mm;

   rsp_item_type motor_reports[$];
   rsp_item_type seen_rsp;
   rsp_item_type due_rsp;

   int unsigned error_count;
   int unsigned hold_left;
   int unsigned quiet_cycles;
   bit          gaps_on;
   bit          hold_ask;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit above_top();
      return longint'(est_height) > longint'(lim_max) - longint'(tol_mm);
   endfunction

   function automatic bit below_bottom();
      return longint'(est_height) < longint'(lim_min) + longint'(tol_mm);
   endfunction

   function automatic void update_height();
      longint num;
      longint h;
      if (actual_mv == MOT_UP) begin
         h = longint'(base_mm)
             + (longint'(up_rate) * longint'(run_ms)) / longint'(MS_PER_S);
         if (h > longint'(H_MAX)) h = longint'(H_MAX);
         est_height = h[H_W-1:0];
      end else if (actual_mv == MOT_DOWN) begin
         num = longint'(base_mm) * longint'(MS_PER_S)
               - longint'(down_rate) * longint'(run_ms);
         if (num <= 0) begin
            h = 0;
         end else begin
            h = num / longint'(MS_PER_S);
            if (h > longint'(H_MAX)) h = longint'(H_MAX);
         end
         est_height = h[H_W-1:0];
      end
   endfunction

   function automatic logic desk_tick();
      logic   saved;
      longint cur;
      longint tgt;
      longint tol;
      saved = 1'b0;
      if (actual_mv != MOT_STOP && run_ms != TIME_MAX) run_ms = run_ms + 1'b1;
      update_height();
      if (actual_mv != wanted_mv) begin
         if (wanted_mv == MOT_UP) begin
            if (!above_top()) actual_mv = MOT_UP;
         end else if (wanted_mv == MOT_DOWN) begin
            if (!below_bottom()) actual_mv = MOT_DOWN;
         end else begin
            actual_mv = MOT_STOP;
            base_mm   = est_height;
            run_ms    = '0;
            saved     = 1'b1;
         end
      end
      cur = longint'(est_height);
      tgt = longint'(goal_mm);
      tol = longint'(tol_mm);
      // timeout, end limit, or arrival inside the target window
      if ((actual_mv != MOT_STOP && limit_ms != '0 && run_ms >= limit_ms)
          || (actual_mv == MOT_UP && above_top())
          || (actual_mv == MOT_DOWN && below_bottom())
          || (cur > tgt - tol && cur < tgt + tol)) begin
         wanted_mv = MOT_STOP;
         limit_ms  = '0;
      end
      return saved;
   endfunction

   function automatic rsp_item_type advance_desk(req_item_type it);
      rsp_item_type r;
      logic         saved;
      status_type   status;
      longint       gap;
      longint       tol;
      longint       tgt;
      saved  = 1'b0;
      status = STS_ACCEPTED;
      tol    = longint'(tol_mm);
      tgt    = longint'(it.target_mm);
      case (it.opcode)
         OP_TICK: saved = desk_tick();
         OP_UP: begin
            wanted_mv = MOT_UP;
            limit_ms  = it.duration_ms;
         end
         OP_DOWN: begin
            wanted_mv = MOT_DOWN;
            limit_ms  = it.duration_ms;
         end
         OP_STOP: begin
            wanted_mv = MOT_STOP;
            limit_ms  = '0;
         end
         OP_TARGET: begin
            gap = longint'(est_height) - tgt;
            if (gap < 0) gap = -gap;
            if (gap <= tol) begin
               status = STS_AT_TARGET;
            end else if (!(tgt > longint'(lim_min) + tol
                           && tgt < longint'(lim_max) - tol)) begin
               status = STS_OUT_OF_RANGE;
            end else begin
               goal_mm = it.target_mm;
               if (est_height < it.target_mm) wanted_mv = MOT_UP;
               else wanted_mv = MOT_DOWN;
            end
         end
         OP_LOAD: begin
            est_height = it.load_height_mm;
            base_mm    = it.load_height_mm;
         end
         default: ;
      endcase
      r.motor_up       = (actual_mv == MOT_UP);
      r.motor_down     = (actual_mv == MOT_DOWN);
      r.height_mm      = est_height;
      r.motion         = actual_mv;
      r.position_saved = saved;
      r.command_status = status;
      return r;
   endfunction

   task automatic check_field(string what, longint got, longint want_v);
      if (got != want_v) begin
         error_count++;
         if (error_count <= MAX_PRINTS)
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want_v, $realtime);
      end
   endtask

   // result side: compare each transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_rsp.motor_up       = rsp_bus.motor_up;
         seen_rsp.motor_down     = rsp_bus.motor_down;
         seen_rsp.height_mm      = rsp_bus.height_mm;
         seen_rsp.motion         = rsp_bus.motion;
         seen_rsp.position_saved = rsp_bus.position_saved;
         seen_rsp.command_status = rsp_bus.command_status;
         if (motor_reports.size() == 0) begin
            check_field("result with no request", 1, 0);
         end else begin
            due_rsp = motor_reports.pop_front();
            check_field("motor_up", seen_rsp.motor_up, due_rsp.motor_up);
            check_field("motor_down", seen_rsp.motor_down, due_rsp.motor_down);
            check_field("height_mm", seen_rsp.height_mm, due_rsp.height_mm);
            check_field("motion", seen_rsp.motion, due_rsp.motion);
            check_field("position_saved", seen_rsp.position_saved, due_rsp.position_saved);
            check_field("command_status", seen_rsp.command_status, due_rsp.command_status);
         end
      end
   end

   // receiver: random gaps plus a long hold-off when a test asks for one
   initial begin
      rsp_bus.ready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            hold_ask  = 1'b0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("testbench: errors");
      $finish;
   end

   function automatic req_item_type cmd(logic [OP_W-1:0] op, logic [TIME_W-1:0] dur,
                                        logic [H_W-1:0] tgt, logic [H_W-1:0] load);
      req_item_type it;
      it.opcode         = op;
      it.duration_ms    = dur;
      it.target_mm      = tgt;
      it.load_height_mm = load;
      return it;
   endfunction

   function automatic req_item_type noise_item();
      return cmd(OP_W'($urandom_range(7)), $urandom, H_W'($urandom_range(4095)),
                 H_W'($urandom_range(4095)));
   endfunction

   function automatic logic [TIME_W-1:0] pick_duration();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 40) return '0;
      if (r < 85) return TIME_W'($urandom_range(120, 1));
      return $urandom;
   endfunction

   function automatic logic [H_W-1:0] pick_height();
      int r;
      int v;
      int off;
      r   = $urandom_range(99);
      off = $urandom_range(6);
      off -= 3;
      if (r < 15) v = int'(lim_max) - int'(tol_mm) + off;
      else if (r < 30) v = int'(lim_min) + int'(tol_mm) + off;
      else if (r < 40 || lim_min > lim_max) v = $urandom_range(4095);
      else v = $urandom_range(lim_max, lim_min);
      if (v < 0) v = 0;
      if (v > int'(H_MAX)) v = int'(H_MAX);
      return v[H_W-1:0];
   endfunction

   function automatic logic [H_W-1:0] pick_target(logic [H_W-1:0] from);
      int lo;
      int hi;
      int v;
      int r;
      lo = int'(lim_min) + int'(tol_mm) + 1;
      hi = int'(lim_max) - int'(tol_mm) - 1;
      r  = $urandom_range(99);
      if (r < 50 && lo <= hi) begin
         v = $urandom_range(hi, lo);
      end else if (r < 80) begin
         // just outside the window so the target check has work to do
         v = int'($urandom_range(20)) + int'(tol_mm) + 1;
         if ($urandom_range(1)) v = -v;
         v += int'(from);
      end else begin
         v = $urandom_range(4095);
      end
      if (v < 0) v = 0;
      if (v > int'(H_MAX)) v = int'(H_MAX);
      return v[H_W-1:0];
   endfunction

   task automatic push_command(req_item_type it);
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.opcode         <= it.opcode;
      req_bus.duration_ms    <= it.duration_ms;
      req_bus.target_mm      <= it.target_mm;
      req_bus.load_height_mm <= it.load_height_mm;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      motor_reports.push_back(advance_desk(it));
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (motor_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_MIN_HEIGHT: lim_min   = val[H_W-1:0];
         CSR_MAX_HEIGHT: lim_max   = val[H_W-1:0];
         CSR_MARGIN:     tol_mm    = val[MAR_W-1:0];
         CSR_UP_SPEED:   up_rate   = val[SPD_W-1:0];
         CSR_DOWN_SPEED: down_rate = val[SPD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_limits(logic [CSR_DATA_W-1:0] lo, logic [CSR_DATA_W-1:0] hi,
                             logic [CSR_DATA_W-1:0] tol, logic [CSR_DATA_W-1:0] up,
                             logic [CSR_DATA_W-1:0] down);
      settle();
      put_csr(CSR_MIN_HEIGHT, lo);
      put_csr(CSR_MAX_HEIGHT, hi);
      put_csr(CSR_MARGIN, tol);
      put_csr(CSR_UP_SPEED, up);
      put_csr(CSR_DOWN_SPEED, down);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_item_type stray_command();
      case ($urandom_range(4))
         0: return cmd(OP_UP, pick_duration(), H_W'($urandom_range(4095)),
                       H_W'($urandom_range(4095)));
         1: return cmd(OP_DOWN, pick_duration(), H_W'($urandom_range(4095)),
                       H_W'($urandom_range(4095)));
         2: return cmd(OP_STOP, $urandom, H_W'($urandom_range(4095)),
                       H_W'($urandom_range(4095)));
         3: return cmd(OP_TARGET, $urandom, pick_target(est_height),
                       H_W'($urandom_range(4095)));
         default: return cmd(OP_LOAD, $urandom, H_W'($urandom_range(4095)), pick_height());
      endcase
   endfunction

   // travel sessions: load a height, start a move, run the clock, with some noise
   task automatic run_sessions(int unsigned budget);
      int unsigned sent;
      int unsigned ticks;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 20) begin
            push_command(noise_item());
            sent++;
         end else begin
            push_command(cmd(OP_LOAD, $urandom, H_W'($urandom_range(4095)), pick_height()));
            case ($urandom_range(2))
               0: push_command(cmd(OP_UP, pick_duration(), H_W'($urandom_range(4095)), 0));
               1: push_command(cmd(OP_DOWN, pick_duration(), H_W'($urandom_range(4095)), 0));
               default: push_command(cmd(OP_TARGET, 0, pick_target(est_height), 0));
            endcase
            ticks = $urandom_range(80, 10);
            repeat (ticks) begin
               if ($urandom_range(99) < 3) push_command(stray_command());
               else push_command(cmd(OP_TICK, $urandom, H_W'($urandom_range(4095)),
                                     H_W'($urandom_range(4095))));
            end
            sent += ticks + 2;
         end
      end
   endtask

   task automatic test_directed();
      push_command(cmd(OP_TICK, 0, 0, 0));
      push_command(cmd(OP_LOAD, 0, 0, 800));
      // timed move that runs out
      push_command(cmd(OP_UP, 3, 0, 0));
      repeat (5) push_command(cmd(OP_TICK, 0, 0, 0));
      push_command(cmd(OP_TARGET, 0, 12'hFFF, 0));
      push_command(cmd(OP_TARGET, 0, 805, 0));
      push_command(cmd(OP_TARGET, 0, 900, 0));
      repeat (2) push_command(cmd(OP_TICK, 0, 0, 0));
      // reversal without a stop in between
      push_command(cmd(OP_DOWN, 0, 0, 0));
      push_command(cmd(OP_TICK, 0, 0, 0));
      push_command(cmd(OP_SPARE_A, TIME_MAX, 12'hFFF, 12'hFFF));
      push_command(cmd(OP_SPARE_B, 0, 0, 0));
      // load while moving
      push_command(cmd(OP_LOAD, 0, 0, 12'hFFF));
      push_command(cmd(OP_TICK, 0, 0, 0));
      push_command(cmd(OP_STOP, TIME_MAX, 0, 0));
      push_command(cmd(OP_TICK, 0, 0, 0));
      // moves refused at the end limits
      push_command(cmd(OP_LOAD, 0, 0, 1295));
      push_command(cmd(OP_UP, TIME_MAX, 0, 0));
      push_command(cmd(OP_TICK, 0, 0, 0));
      push_command(cmd(OP_LOAD, 0, 0, 0));
      push_command(cmd(OP_DOWN, 0, 0, 0));
      push_command(cmd(OP_TICK, 0, 0, 0));
      push_command(cmd(OP_TARGET, 0, 0, 0));
   endtask

   task automatic test_backpressure();
      settle();
      hold_ask = 1'b1;
      push_command(cmd(OP_LOAD, 0, 0, 900));
      push_command(cmd(OP_UP, 0, 0, 0));
      repeat (38) push_command(cmd(OP_TICK, 0, 0, 0));
   endtask

   task automatic test_default_travel();
      set_limits(12'd600, 12'd1300, 12'd10, 12'd30, 12'd30);
      run_sessions(250);
   endtask

   task automatic test_extreme_limits();
      set_limits(12'd0, 12'hFFF, 12'd0, 12'd255, 12'd255);
      run_sessions(200);
   endtask

   task automatic test_inverted_limits();
      set_limits(12'hFFF, 12'd0, 12'd255, 12'd0, 12'd0);
      run_sessions(150);
   endtask

   task automatic test_random_limits();
      int unsigned lo;
      for (int pass = 0; pass < 3; pass++) begin
         lo = $urandom_range(1200, 100);
         if (pass == 2)
            set_limits(CSR_DATA_W'($urandom_range(4095)), CSR_DATA_W'($urandom_range(4095)),
                       CSR_DATA_W'($urandom_range(4095)), CSR_DATA_W'($urandom_range(4095)),
                       CSR_DATA_W'($urandom_range(4095)));
         else
            set_limits(CSR_DATA_W'(lo), CSR_DATA_W'(lo + $urandom_range(1500, 200)),
                       CSR_DATA_W'($urandom_range(30)), CSR_DATA_W'($urandom_range(255, 60)),
                       CSR_DATA_W'($urandom_range(255, 60)));
         // one stretch with both sides running flat out
         gaps_on = (pass != 1);
         run_sessions(150);
         gaps_on = 1'b1;
      end
   endtask

   initial begin
      reset                  <= 1'b1;
      csr_we                 <= 1'b0;
      csr_index              <= CSR_MIN_HEIGHT;
      csr_wdata              <= '0;
      req_bus.valid          <= 1'b0;
      req_bus.opcode         <= OP_TICK;
      req_bus.duration_ms    <= '0;
      req_bus.target_mm      <= '0;
      req_bus.load_height_mm <= '0;
      error_count = 0;
      gaps_on     = 1'b1;
      hold_ask    = 1'b0;
      lim_min     = MIN_HEIGHT_RST;
      lim_max     = MAX_HEIGHT_RST;
      tol_mm      = MARGIN_RST;
      up_rate     = UP_SPEED_RST;
      down_rate   = DOWN_SPEED_RST;
      est_height  = '0;
      base_mm     = '0;
      run_ms      = '0;
      actual_mv   = MOT_STOP;
      wanted_mv   = MOT_STOP;
      limit_ms    = '0;
      goal_mm     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_default_travel();
      test_extreme_limits();
      test_inverted_limits();
      test_random_limits();

      settle();
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

>>> sim.f
src/dmpc_pkg.sv
src/dmpc_if.sv
src/dmpc_csr.sv
src/dmpc_rescale.sv
src/dmpc_core.sv
src/desk_motor_position_controller.sv
src/dmpc_checker.sv
tb/testbench.sv
